// ----- rtl/complex_iir_filter_core_assert.svh -----
// Assertion macros shared by the complex IIR filter RTL.
`ifndef COMPLEX_IIR_FILTER_CORE_ASSERT_SVH
`define COMPLEX_IIR_FILTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CIFC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cifc: check failed");
`define CIFC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cifc: reset check failed");
`else
`define CIFC_ASSERT(label, prop)
`define CIFC_ASSERT_RST(label, prop)
`endif
`endif

// ----- rtl/cifc_pkg.sv -----
// Shared constants, types and helper functions of the complex IIR filter.
package cifc_pkg;

  // filter order and storage
  localparam int ORDER      = 4;
  localparam int HIDX_W     = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int STAGE_W    = $clog2(ORDER + 1);

  // configuration
  localparam int NUM_WORDS  = 6;
  localparam int WORD_W     = 63;
  localparam int COEF_W     = 21;
  localparam int NUM_SLOTS  = 18;
  localparam int SLOT_W     = 5;
  localparam int SHIFT_W    = 6;
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_WORD_0 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_SHIFT   = 3'd6;

  // coefficient slot bases
  localparam int SLOT_B_RE  = 0;
  localparam int SLOT_B_IM  = 5;
  localparam int SLOT_A_RE  = 8;
  localparam int SLOT_A_IM  = 12;

  // datapath widths
  localparam int SAMPLE_W   = 16;
  localparam int OUT_W      = 24;
  localparam int STATE_W    = 56;
  localparam int ACC_W      = 64;
  localparam int Y_SPLIT    = 28;
  localparam int OPND_W     = STATE_W - Y_SPLIT + 1;
  localparam int PROD_W     = COEF_W + OPND_W;
  localparam int HI_SHIFT   = Y_SPLIT - 16;
  localparam int LO_SHIFT   = 16;
  localparam int OUT_SHIFT  = 16;

  // micro-op sequence
  localparam int OPS_STAGE0 = 2;
  localparam int OPS_HALF   = 5;
  localparam int OPS_STAGE  = 2 * OPS_HALF;
  localparam int OP_W       = $clog2(OPS_STAGE);

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] coef_bank_t;
  typedef logic [NUM_SLOTS-1:0][COEF_W-1:0] coef_slots_t;

  typedef enum logic [2:0] {
    OPND_X,
    OPND_YR_HI,
    OPND_YR_LO,
    OPND_YI_HI,
    OPND_YI_LO
  } opnd_t;

  typedef enum logic [1:0] {
    TERM_BX,
    TERM_HI,
    TERM_LO
  } term_t;

  typedef struct packed {
    logic              vld;
    logic              first;
    logic              last;
    logic              imag;
    logic              to_y;
    logic              hist_zero;
    logic              neg;
    logic [SLOT_W-1:0] slot;
    opnd_t             opnd;
    term_t             term;
    logic [HIDX_W-1:0] ridx;
    logic [HIDX_W-1:0] widx;
  } mac_op_t;

  // Micro-op for step k of stage (stage 0 forms y, stage j updates s(j-1)).
  function automatic mac_op_t op_decode(input logic [STAGE_W-1:0] stage,
                                        input logic [OP_W-1:0] k);
    mac_op_t           o;
    logic [SLOT_W-1:0] j;
    logic              imag;
    logic [OP_W-1:0]   kk;
    o    = '0;
    j    = SLOT_W'(stage);
    imag = 1'b0;
    kk   = '0;
    o.opnd = OPND_X;
    o.term = TERM_BX;
    if (stage == '0) begin
      o.first = 1'b1;
      o.last  = 1'b1;
      o.to_y  = 1'b1;
      o.imag  = k[0];
      o.slot  = k[0] ? SLOT_W'(SLOT_B_IM) : SLOT_W'(SLOT_B_RE);
    end else begin
      imag        = (k >= OP_W'(OPS_HALF));
      kk          = imag ? (k - OP_W'(OPS_HALF)) : k;
      o.imag      = imag;
      o.ridx      = HIDX_W'(stage);
      o.widx      = HIDX_W'(stage - 1'b1);
      o.hist_zero = (stage == STAGE_W'(ORDER));
      case (kk)
        OP_W'(0): begin
          o.first = 1'b1;
          o.slot  = j + (imag ? SLOT_W'(SLOT_B_IM) : SLOT_W'(SLOT_B_RE));
        end
        OP_W'(1): begin
          o.slot = j + SLOT_W'(SLOT_A_RE);
          o.opnd = imag ? OPND_YI_HI : OPND_YR_HI;
          o.term = TERM_HI;
          o.neg  = 1'b1;
        end
        OP_W'(2): begin
          o.slot = j + SLOT_W'(SLOT_A_RE);
          o.opnd = imag ? OPND_YI_LO : OPND_YR_LO;
          o.term = TERM_LO;
          o.neg  = 1'b1;
        end
        OP_W'(3): begin
          o.slot = j + SLOT_W'(SLOT_A_IM);
          o.opnd = imag ? OPND_YR_HI : OPND_YI_HI;
          o.term = TERM_HI;
          o.neg  = imag;
        end
        OP_W'(4): begin
          o.slot = j + SLOT_W'(SLOT_A_IM);
          o.opnd = imag ? OPND_YR_LO : OPND_YI_LO;
          o.term = TERM_LO;
          o.neg  = imag;
          o.last = 1'b1;
        end
        default: begin
          o.slot = '0;
        end
      endcase
    end
    return o;
  endfunction

  // Saturate the accumulator to the signed state range.
  function automatic logic [STATE_W-1:0] sat_state(input logic [ACC_W-1:0] v);
    logic [STATE_W-1:0] r;
    if (v[ACC_W-1:STATE_W-1] == {(ACC_W-STATE_W+1){v[ACC_W-1]}}) begin
      r = v[STATE_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(STATE_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Drop to 8 fraction bits and saturate to the output width.
  function automatic logic [OUT_W-1:0] sat_out(input logic [STATE_W-1:0] y);
    logic [OUT_W-1:0] r;
    if (y[STATE_W-1:OUT_W+OUT_SHIFT-1] ==
        {(STATE_W-OUT_W-OUT_SHIFT+1){y[STATE_W-1]}}) begin
      r = y[OUT_W+OUT_SHIFT-1:OUT_SHIFT];
    end else if (y[STATE_W-1]) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- rtl/cifc_mac.sv -----
// Shared multiplier, accumulator and filter state of the complex IIR filter.
`include "complex_iir_filter_core_assert.svh"

module cifc_mac (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     load,
  input  logic signed [cifc_pkg::SAMPLE_W-1:0]     sample,
  input  cifc_pkg::coef_bank_t                     coef_bank,
  input  logic        [cifc_pkg::SHIFT_W-1:0]      num_shift,
  input  cifc_pkg::mac_op_t                        op,
  output logic        [cifc_pkg::STATE_W-1:0]      y_re,
  output logic        [cifc_pkg::STATE_W-1:0]      y_im
);
  import cifc_pkg::*;

  coef_slots_t               coef_slots;
  logic signed [COEF_W-1:0]  coef_s;
  logic signed [OPND_W-1:0]  opnd_s;
  logic signed [PROD_W-1:0]  prod;

  logic signed [SAMPLE_W-1:0] x_reg;
  logic signed [PROD_W-1:0]   p_reg;
  mac_op_t                    ctl_q;
  logic        [ACC_W-1:0]    acc;
  logic        [STATE_W-1:0]  yr;
  logic        [STATE_W-1:0]  yi;
  logic        [STATE_W-1:0]  hist_re [ORDER];
  logic        [STATE_W-1:0]  hist_im [ORDER];

  logic signed [ACC_W-1:0]    p_ext;
  logic signed [ACC_W-1:0]    term;
  logic        [STATE_W-1:0]  hist_val;
  logic        [ACC_W-1:0]    base;
  logic        [ACC_W-1:0]    sum;
  logic        [STATE_W-1:0]  sum_sat;

  // issue: coefficient and operand select, one multiply
  assign coef_slots = coef_slots_t'(coef_bank);

  always_comb begin
    if (op.slot < SLOT_W'(NUM_SLOTS)) begin
      coef_s = coef_slots[op.slot];
    end else begin
      coef_s = '0;
    end
    case (op.opnd)
      OPND_X:     opnd_s = {{(OPND_W-SAMPLE_W){x_reg[SAMPLE_W-1]}}, x_reg};
      OPND_YR_HI: opnd_s = {yr[STATE_W-1], yr[STATE_W-1:Y_SPLIT]};
      OPND_YR_LO: opnd_s = {1'b0, yr[Y_SPLIT-1:0]};
      OPND_YI_HI: opnd_s = {yi[STATE_W-1], yi[STATE_W-1:Y_SPLIT]};
      OPND_YI_LO: opnd_s = {1'b0, yi[Y_SPLIT-1:0]};
      default:    opnd_s = '0;
    endcase
  end

  assign prod = coef_s * opnd_s;

  // accumulate: scale the product, add to history or running sum
  assign p_ext = {{(ACC_W-PROD_W){p_reg[PROD_W-1]}}, p_reg};

  always_comb begin
    case (ctl_q.term)
      TERM_BX: term = p_ext >>> num_shift;
      TERM_HI: term = p_ext <<< HI_SHIFT;
      TERM_LO: term = p_ext >>> LO_SHIFT;
      default: term = '0;
    endcase
    if (ctl_q.hist_zero) begin
      hist_val = '0;
    end else if (ctl_q.imag) begin
      hist_val = hist_im[ctl_q.ridx];
    end else begin
      hist_val = hist_re[ctl_q.ridx];
    end
    base    = ctl_q.first ? {{(ACC_W-STATE_W){hist_val[STATE_W-1]}}, hist_val} : acc;
    sum     = ctl_q.neg ? (base - term) : (base + term);
    sum_sat = sat_state(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= op;
    end
  end

  always_ff @(posedge clk) begin
    p_reg <= prod;
    if (load) begin
      x_reg <= sample;
    end
    if (ctl_q.vld) begin
      acc <= sum;
      if (ctl_q.last && ctl_q.to_y) begin
        if (ctl_q.imag) begin
          yi <= sum_sat;
        end else begin
          yr <= sum_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ORDER; i++) begin
        hist_re[i] <= '0;
        hist_im[i] <= '0;
      end
    end else if (ctl_q.vld && ctl_q.last && !ctl_q.to_y) begin
      if (ctl_q.imag) begin
        hist_im[ctl_q.widx] <= sum_sat;
      end else begin
        hist_re[ctl_q.widx] <= sum_sat;
      end
    end
  end

  assign y_re = yr;
  assign y_im = yi;

  // a new sample must not land while a micro-op is still in the pipe
  `CIFC_ASSERT(a_load_pipe_empty, load |-> (!ctl_q.vld && !op.vld))
  `CIFC_ASSERT_RST(a_rst_clears_pipe, rst |=> !ctl_q.vld)

endmodule

// ----- rtl/cifc_seq.sv -----
// Micro-op sequencer and handshake control of the complex IIR filter.
`include "complex_iir_filter_core_assert.svh"

module cifc_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              load,
  output logic              out_load,
  output cifc_pkg::mac_op_t op
);
  import cifc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t             state;
  logic [STAGE_W-1:0] stage;
  logic [OP_W-1:0]    opi;

  assign in_stall = (state != S_IDLE);
  assign load     = in_valid && !in_stall;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    op     = op_decode(stage, opi);
    op.vld = (state == S_RUN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stage     <= '0;
      opi       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (load) begin
            stage <= '0;
            opi   <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (stage == '0) begin
            if (opi == OP_W'(OPS_STAGE0 - 1)) begin
              stage <= STAGE_W'(1);
              opi   <= '0;
            end else begin
              opi <= opi + 1'b1;
            end
          end else if (opi == OP_W'(OPS_STAGE - 1)) begin
            if (stage == STAGE_W'(ORDER)) begin
              state <= S_DONE;
            end else begin
              stage <= stage + 1'b1;
              opi   <= '0;
            end
          end else begin
            opi <= opi + 1'b1;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CIFC_ASSERT(a_slot_range, op.vld |-> (op.slot < SLOT_W'(NUM_SLOTS)))
  `CIFC_ASSERT(a_done_after_last, (state == S_DONE) |-> (stage == STAGE_W'(ORDER)))
  `CIFC_ASSERT(a_result_from_done, $rose(out_valid) |-> $past(state == S_DONE))
  `CIFC_ASSERT_RST(a_rst_no_result, rst |=> !out_valid)

endmodule

// ----- rtl/complex_iir_filter_core.sv -----
// Top level of the fourth-order complex-coefficient IIR filter core.
//
// Fourth-order complex-coefficient IIR filter, transposed direct form II, on a
// real 16-bit input. Each sample x gives y = b0*x + s0; then every delay
// element is updated as s(j-1) = bj*x - aj*y + s(j). All arithmetic runs on
// one shared 21 x 29 bit signed multiplier followed by a 64-bit accumulator.
// A complex a*y product takes four real products, and each real product with
// the 56-bit y is done as two partial products (high and low halves of y), so
// one sample costs 2 multiplies for y plus 10 per stage, 42 multiplies in all.
// After a sample is accepted its micro-ops are issued in order; the accumulate
// stage drains after the last issue, and the result goes to the output
// register once that register is free. in_stall stays high while a sample is
// in work and while a finished result waits for a free output register.
// Coefficients come in six 63-bit words, three signed 21-bit fields each
// (b_re0..4, b_im0..4, a_re1..4, a_im1..4; b_im4 and a_re1 share one field);
// a is Q4.16, b*x is shifted right by num_shift into the 24-fraction-bit
// state. Outputs keep 8 fraction bits, saturated to 24 bits.
// Configuration writes are only legal while the core is idle.

module complex_iir_filter_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [cifc_pkg::SAMPLE_W-1:0]   sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [cifc_pkg::OUT_W-1:0]      out_re,
  output logic signed [cifc_pkg::OUT_W-1:0]      out_im,
  input  logic                                   cfg_we,
  input  logic        [cifc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic        [cifc_pkg::WORD_W-1:0]     cfg_wdata
);
  import cifc_pkg::*;

  coef_bank_t          coef_bank;
  logic [SHIFT_W-1:0]  num_shift;
  logic                load;
  logic                out_load;
  mac_op_t             op;
  logic [STATE_W-1:0]  y_re;
  logic [STATE_W-1:0]  y_im;

  // config registers: coefficient words at indexes 0..5, shift at 6;
  // index 7 is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_bank <= '0;
      num_shift <= '0;
    end else if (cfg_we) begin
      if (cfg_addr < (REG_COEF_WORD_0 + CFG_ADDR_W'(NUM_WORDS))) begin
        coef_bank[cfg_addr] <= cfg_wdata;
      end else if (cfg_addr == REG_NUM_SHIFT) begin
        num_shift <= cfg_wdata[SHIFT_W-1:0];
      end
    end
  end

  // sequencer: handshakes and micro-op stream
  cifc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .load      (load),
    .out_load  (out_load),
    .op        (op)
  );

  // shared multiply-accumulate unit, holds y and the delay line
  cifc_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .sample    (sample),
    .coef_bank (coef_bank),
    .num_shift (num_shift),
    .op        (op),
    .y_re      (y_re),
    .y_im      (y_im)
  );

  // output register; y is final long before the sequence ends
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_re <= sat_out(y_re);
      out_im <= sat_out(y_im);
    end
  end

endmodule
